@@ rtl/lnra_pkg.sv @@
// ----------------------------------------------------------------------------
// lnra_pkg
// Shared types and constants of the logistic neighbor rate accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lnra_pkg;

	localparam int MAX_ATOMS_DEF     = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int RATE_W  = 32;
	localparam int ATOM_W  = 10;
	localparam int INDEX_W = 3;
	localparam int WDATA_W = 63;

	// ln 2 in Q.32
	localparam logic [37:0] LN2_Q32 = 38'h00B17217F8;
	localparam logic [30:0] INVERSE_WIDTH_RESET = 31'd65536;
	localparam int SERIES_TERMS = 13;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PAIR  = 2'd1,
		OP_READ  = 2'd2
	} lnra_op_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_BASE_BIRTH    = 3'd0,
		REG_BIRTH_STEP    = 3'd1,
		REG_DEATH_STEP    = 3'd2,
		REG_CENTER        = 3'd3,
		REG_INVERSE_WIDTH = 3'd4,
		REG_CUTOFF_SQ     = 3'd5
	} lnra_reg_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_SQ,
		ST_CMP,
		ST_SQRT,
		ST_MAG,
		ST_UMUL,
		ST_RANGE,
		ST_REDUCE,
		ST_EMUL,
		ST_EDIV,
		ST_EACC,
		ST_PSET,
		ST_PDIV,
		ST_SVAL,
		ST_STEP,
		ST_AP_RD,
		ST_AP_WR,
		ST_RD_I,
		ST_RD_J,
		ST_OUT
	} lnra_state_t;

endpackage

`default_nettype wire

@@ rtl/lnra_if.sv @@
// ----------------------------------------------------------------------------
// lnra_if
// Item and result channels of the logistic neighbor rate accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnra_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [9:0]         first_atom;
	logic [9:0]         second_atom;
	logic               update_second;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;

	modport source (output valid, operation, first_atom, second_atom, update_second,
		first_x, first_y, first_z, second_x, second_y, second_z, input ready);
	modport sink (input valid, operation, first_atom, second_atom, update_second,
		first_x, first_y, first_z, second_x, second_y, second_z, output ready);
endinterface

interface lnra_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_birth;
	logic signed [31:0] first_death;
	logic signed [31:0] second_birth;
	logic signed [31:0] second_death;
	logic               within_cutoff;

	modport source (output valid, first_birth, first_death, second_birth, second_death,
		within_cutoff, input ready);
	modport sink (input valid, first_birth, first_death, second_birth, second_death,
		within_cutoff, output ready);
endinterface

`default_nettype wire

@@ rtl/logistic_neighbor_rate_accumulator.sv @@
// ----------------------------------------------------------------------------
// logistic_neighbor_rate_accumulator
// Per-atom birth and death rate accumulators updated by a logistic weight of
// the pair distance, with start, pair and read operations.
// ----------------------------------------------------------------------------
//  channel   direction  beat
//  item      in         operation, atom indices, update_second, two positions
//  result    out        rates of both atoms, within_cutoff
//  wr_*      in         register write, no handshake
//
//  After reset a clearing pass zeroes both rate memories, during which no
//  item is taken. Items are handled one at a time. A pair outside the
//  cutoff skips the square root and the rate update. A pair inside the
//  cutoff is slowest, set by the bit-serial square root and the bit-serial
//  divider that the exponential series and the final quotient share. A new
//  item is taken while the previous result still waits in the output
//  register; the last step of an item waits for that register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module logistic_neighbor_rate_accumulator
	import lnra_pkg::*;
#(
	parameter int MAX_ATOMS     = MAX_ATOMS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	lnra_item_if.sink                 item,
	lnra_result_if.source             result,
	input  wire logic                 wr_en,
	input  wire logic [INDEX_W-1:0]   wr_index,
	input  wire logic [WDATA_W-1:0]   wr_data
);

	localparam int F   = FRACTION_BITS;
	localparam int AW  = $clog2(MAX_ATOMS);
	localparam int DW  = 2 * F + 35;
	localparam int SW  = F + 1;
	localparam int NW  = $clog2(F + 3);
	localparam int SHR = (2 * F >= 32) ? 2 * F - 32 : 0;
	localparam int SHL = (2 * F < 32) ? 32 - 2 * F : 0;

	// configuration
	logic [31:0] base_birth_q, birth_step_q, death_step_q;
	logic [30:0] center_q, inv_width_q;
	logic [62:0] cutoff_q;

	lnra_state_t state_q, state_d;

	// captured item
	logic [1:0]  op_q;
	logic [9:0]  ai_q, aj_q;
	logic        both_q;
	logic [31:0] px_q [6];

	logic [AW-1:0] clr_cnt_q;
	logic [5:0]    cnt_q;
	logic [63:0]   sq_q, sum_q;
	logic [63:0]   v_q, res_q, bit_q;
	logic          inside_q, negf_q;
	logic [31:0]   mag_q;
	logic [62:0]   u_q;
	logic [37:0]   q_q;
	logic [NW-1:0] n_q;
	logic [32:0]   term_q;
	logic signed [33:0] esum_q;
	logic [3:0]    k_q;
	logic [DW-1:0] rem_q, dsh_q;
	logic [32:0]   quot_q;
	logic [SW-1:0] p_q, s_q;
	logic signed [33:0] sb_q, sd_q;
	logic          cur_sel_q;
	logic [31:0]   fb_q, fd_q;

	// memories
	logic [31:0]   birth_mem [MAX_ATOMS];
	logic [31:0]   death_mem [MAX_ATOMS];
	logic [31:0]   rd_birth_q, rd_death_q;
	logic [AW-1:0] mem_addr;
	logic          we_birth, we_death;
	logic [31:0]   wd_birth, wd_death;

	// output register
	logic        out_valid_q;
	logic [31:0] o_fb_q, o_fd_q, o_sb_q, o_sd_q;
	logic        o_in_q;

	logic        ai_ok, aj_ok, cur_ok, clr_last, out_free;
	logic [9:0]  cur_atom;
	logic [32:0] dx;
	logic [31:0] dabs;
	logic [64:0] sum_add;
	logic [63:0] root_try;
	logic [64:0] term_prod;
	logic        div_ge;
	logic [32:0] quot_nxt;
	logic [DW-1:0] den, num;
	logic signed [F+33:0] prod_b, prod_d;
	logic signed [34:0] birth_new, death_new;
	logic        u_big;

	function automatic logic [31:0] sat32(input logic signed [34:0] x);
		logic [31:0] y;
		if (x > 35'sd2147483647)
			y = 32'h7FFF_FFFF;
		else if (x < -35'sd2147483648)
			y = 32'h8000_0000;
		else
			y = x[31:0];
		return y;
	endfunction

	assign ai_ok    = 32'(ai_q) < 32'(MAX_ATOMS);
	assign aj_ok    = 32'(aj_q) < 32'(MAX_ATOMS);
	assign cur_atom = cur_sel_q ? aj_q : ai_q;
	assign cur_ok   = cur_sel_q ? aj_ok : ai_ok;
	assign clr_last = clr_cnt_q == AW'(MAX_ATOMS - 1);
	assign out_free = !out_valid_q || result.ready;

	// datapath helpers
	always_comb begin
		dx = $signed({px_q[3'(cnt_q[1:0])][31], px_q[3'(cnt_q[1:0])]})
			- $signed({px_q[3'(cnt_q[1:0]) + 3'd3][31], px_q[3'(cnt_q[1:0]) + 3'd3]});
		dabs = dx[32] ? 32'(-dx) : dx[31:0];
		sum_add = {1'b0, sum_q} + {1'b0, sq_q};
		root_try = res_q + bit_q;
		term_prod = 65'(term_q) * 65'(q_q[31:0]);
		div_ge = rem_q >= dsh_q;
		quot_nxt = {quot_q[31:0], div_ge};
		den = (DW'(1) << (32 + 32'(n_q))) + DW'(esum_q[32:0]);
		num = (DW'(esum_q[32:0]) << F) + (den >> 1);
		prod_b = $signed(birth_step_q) * $signed({1'b0, s_q});
		prod_d = $signed(death_step_q) * $signed({1'b0, s_q});
		birth_new = $signed({{3{rd_birth_q[31]}}, rd_birth_q}) - $signed({sb_q[33], sb_q});
		death_new = $signed({{3{rd_death_q[31]}}, rd_death_q}) + $signed({sd_q[33], sd_q});
		u_big = 64'(u_q) >= (64'(64) << (2 * F));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (item.valid) begin
					case (item.operation)
						OP_START: state_d = ST_START;
						OP_PAIR:  state_d = ST_SQ;
						OP_READ:  state_d = ST_RD_I;
						default:  state_d = ST_OUT;
					endcase
				end
			end
			ST_START:  state_d = ST_RD_I;
			ST_SQ:     if (cnt_q == 6'd3) state_d = ST_CMP;
			ST_CMP:    state_d = (sum_q < {1'b0, cutoff_q}) ? ST_SQRT : ST_RD_I;
			ST_SQRT:   if (cnt_q == 6'd31) state_d = ST_MAG;
			ST_MAG:    state_d = ST_UMUL;
			ST_UMUL:   state_d = ST_RANGE;
			ST_RANGE:  state_d = u_big ? ST_SVAL : ST_REDUCE;
			ST_REDUCE: begin
				if (q_q >= LN2_Q32) begin
					if (n_q == NW'(F + 1)) state_d = ST_SVAL;
				end else begin
					state_d = ST_EMUL;
				end
			end
			ST_EMUL:   state_d = ST_EDIV;
			ST_EDIV:   if (cnt_q == 6'd1) state_d = ST_EACC;
			ST_EACC:   state_d = (k_q == 4'(SERIES_TERMS)) ? ST_PSET : ST_EMUL;
			ST_PSET:   state_d = ST_PDIV;
			ST_PDIV:   if (cnt_q == 6'd1) state_d = ST_SVAL;
			ST_SVAL:   state_d = ST_STEP;
			ST_STEP:   state_d = ST_AP_RD;
			ST_AP_RD:  state_d = ST_AP_WR;
			ST_AP_WR:  state_d = (!cur_sel_q && both_q) ? ST_AP_RD : ST_RD_I;
			ST_RD_I:   state_d = ST_RD_J;
			ST_RD_J:   state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// handshake and memory controls
	always_comb begin
		item.ready = 1'b0;
		mem_addr   = AW'(ai_q);
		we_birth   = 1'b0;
		we_death   = 1'b0;
		wd_birth   = sat32(birth_new);
		wd_death   = sat32(death_new);
		case (state_q)
			ST_CLEAR: begin
				mem_addr = clr_cnt_q;
				we_birth = 1'b1;
				we_death = 1'b1;
				wd_birth = '0;
				wd_death = '0;
			end
			ST_IDLE:  item.ready = 1'b1;
			ST_START: begin
				we_birth = ai_ok;
				wd_birth = base_birth_q;
			end
			ST_AP_RD: mem_addr = AW'(cur_atom);
			ST_AP_WR: begin
				mem_addr = AW'(cur_atom);
				we_birth = cur_ok;
				we_death = cur_ok;
			end
			ST_RD_J:  mem_addr = AW'(aj_q);
			// Keep the atom j read data in place while the output register is busy.
			ST_OUT:   mem_addr = AW'(aj_q);
			default:  mem_addr = AW'(ai_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_birth) birth_mem[mem_addr] <= wd_birth;
		if (we_death) death_mem[mem_addr] <= wd_death;
		rd_birth_q <= birth_mem[mem_addr];
		rd_death_q <= death_mem[mem_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_birth_q <= '0;
			birth_step_q <= '0;
			death_step_q <= '0;
			center_q     <= '0;
			inv_width_q  <= INVERSE_WIDTH_RESET;
			cutoff_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE_BIRTH:    base_birth_q <= wr_data[31:0];
				REG_BIRTH_STEP:    birth_step_q <= wr_data[31:0];
				REG_DEATH_STEP:    death_step_q <= wr_data[31:0];
				REG_CENTER:        center_q     <= wr_data[30:0];
				REG_INVERSE_WIDTH: inv_width_q  <= wr_data[30:0];
				REG_CUTOFF_SQ:     cutoff_q     <= wr_data;
				default:           ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q     <= item.operation;
				ai_q     <= item.first_atom;
				aj_q     <= item.second_atom;
				both_q   <= item.update_second;
				px_q[0]  <= item.first_x;
				px_q[1]  <= item.first_y;
				px_q[2]  <= item.first_z;
				px_q[3]  <= item.second_x;
				px_q[4]  <= item.second_y;
				px_q[5]  <= item.second_z;
				sum_q    <= '0;
				cnt_q    <= '0;
				inside_q <= 1'b0;
			end
			ST_SQ: begin
				// Square of one axis per cycle, added to the sum in the next cycle.
				if (cnt_q != 6'd3) sq_q <= 64'(dabs) * 64'(dabs);
				if (cnt_q != 6'd0) sum_q <= sum_add[64] ? '1 : sum_add[63:0];
				cnt_q <= cnt_q + 6'd1;
			end
			ST_CMP: begin
				inside_q <= sum_q < {1'b0, cutoff_q};
				v_q      <= sum_q;
				res_q    <= '0;
				bit_q    <= 64'h4000_0000_0000_0000;
				cnt_q    <= '0;
			end
			ST_SQRT: begin
				if (v_q >= root_try) begin
					v_q   <= v_q - root_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 6'd1;
			end
			ST_MAG: begin
				if ({1'b0, center_q} > res_q[31:0]) begin
					mag_q <= {1'b0, center_q} - res_q[31:0];
					negf_q <= inv_width_q != '0;
				end else begin
					mag_q <= res_q[31:0] - {1'b0, center_q};
					negf_q <= 1'b0;
				end
			end
			ST_UMUL: u_q <= 63'(mag_q) * 63'(inv_width_q);
			ST_RANGE: begin
				p_q <= '0;
				q_q <= 38'((64'(u_q) >> SHR) << SHL);
				n_q <= '0;
			end
			ST_REDUCE: begin
				// One subtraction of ln 2 per cycle; too many means the fraction p is zero (one for a distance below the center).
				if (q_q >= LN2_Q32) begin
					p_q <= '0;
					if (n_q != NW'(F + 1)) begin
						q_q <= q_q - LN2_Q32;
						n_q <= n_q + NW'(1);
					end
				end else begin
					term_q <= 33'h1_0000_0000;
					esum_q <= 34'sh1_0000_0000;
					k_q    <= 4'd1;
				end
			end
			ST_EMUL: begin
				rem_q  <= DW'(term_prod[64:32]);
				dsh_q  <= DW'(k_q) << 32;
				quot_q <= '0;
				cnt_q  <= 6'd33;
			end
			ST_EDIV, ST_PDIV: begin
				if (div_ge) rem_q <= rem_q - dsh_q;
				dsh_q  <= dsh_q >> 1;
				quot_q <= quot_nxt;
				cnt_q  <= cnt_q - 6'd1;
				if (state_q == ST_PDIV) p_q <= quot_nxt[SW-1:0];
			end
			ST_EACC: begin
				if (k_q[0])
					esum_q <= esum_q - $signed({1'b0, quot_q});
				else
					esum_q <= esum_q + $signed({1'b0, quot_q});
				term_q <= quot_q;
				k_q    <= k_q + 4'd1;
			end
			ST_PSET: begin
				rem_q  <= num;
				dsh_q  <= den << F;
				quot_q <= '0;
				cnt_q  <= 6'(F + 1);
			end
			ST_SVAL: s_q <= negf_q ? ((SW'(1) << F) - p_q) : p_q;
			ST_STEP: begin
				sb_q      <= prod_b[F+33:F];
				sd_q      <= prod_d[F+33:F];
				cur_sel_q <= 1'b0;
			end
			ST_AP_WR: if (!cur_sel_q && both_q) cur_sel_q <= 1'b1;
			ST_RD_J: begin
				fb_q <= rd_birth_q;
				fd_q <= rd_death_q;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			if (op_q == OP_START || op_q == OP_PAIR || op_q == OP_READ) begin
				o_fb_q <= ai_ok ? fb_q : '0;
				o_fd_q <= ai_ok ? fd_q : '0;
			end else begin
				o_fb_q <= '0;
				o_fd_q <= '0;
			end
			o_sb_q <= (op_q == OP_PAIR && aj_ok) ? rd_birth_q : '0;
			o_sd_q <= (op_q == OP_PAIR && aj_ok) ? rd_death_q : '0;
			o_in_q <= (op_q == OP_PAIR) && inside_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.first_birth   = o_fb_q;
	assign result.first_death   = o_fd_q;
	assign result.second_birth  = o_sb_q;
	assign result.second_death  = o_sd_q;
	assign result.within_cutoff = o_in_q;

`ifndef ASSERT_OFF
	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !item.ready)
		else $error("item taken during clearing pass");
	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we_birth && !we_death)
		else $error("rate memory written while idle");
	a_divider_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EDIV || state_q == ST_PDIV) |-> cnt_q != 6'd0)
		else $error("divider ran past its last step");
	a_series_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMUL |-> (k_q >= 4'd1 && k_q <= 4'(SERIES_TERMS)))
		else $error("series term index out of range");
`endif

endmodule

`default_nettype wire
